### rtl/assert_macros.svh
// Assertion macros shared by the buffer pool RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

### rtl/bplru_pkg.sv
// Types, widths and codes shared by the buffer pool frame manager.
package bplru_pkg;

	localparam int FRAMES_DEF = 8;
	localparam int REQ_W      = 2;
	localparam int STAT_W     = 2;
	localparam int PAGE_W     = 31;
	localparam int PIN_W      = 16;
	localparam int STAMP_W    = 64;
	localparam int CNT_W      = 32;
	localparam int FRAME_W    = 8;

	// request codes
	localparam logic [REQ_W-1:0] REQ_FETCH = 2'd0;
	localparam logic [REQ_W-1:0] REQ_UNPIN = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FLUSH = 2'd2;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ABSENT    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NO_VICTIM = 2'd2;

	localparam logic [PIN_W-1:0] PIN_MAX = {PIN_W{1'b1}};
	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// one frame table entry
	typedef struct packed {
		logic [PAGE_W-1:0]  page;
		logic [PIN_W-1:0]   pins;
		logic               dirty;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic scan_rd;
		logic commit;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic addr_last;
		logic slot_free;
	} ctl_sts_t;

endpackage

### rtl/buffer_pool_lru_frame_manager_unit.sv
// Buffer pool frame manager with LRU replacement and pin counts (top level).
//
// Input channel (in_valid / in_stall) takes one request item: req_type,
// page_id and mark_dirty. Output channel (out_valid / out_stall) returns
// exactly one result item per request, in order.
// Each request walks the frame table one frame per cycle through the single
// registered read port of the table memory, then commits its update; a new
// item is taken in the cycle after the previous one commits, and not before.
// A finished result sits in an output register; the next request is accepted
// and scanned while it waits, and holds at commit only if that result is
// still stalled.
// Reset (arst_n, asynchronous, active low) marks every frame free and clears
// the use clock and the hit and miss counters; the table contents need no
// clearing pass, since entries are read only behind their valid bits.
module buffer_pool_lru_frame_manager_unit #(
	parameter int FRAMES = bplru_pkg::FRAMES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bplru_pkg::REQ_W-1:0]   req_type,
	input  logic [bplru_pkg::PAGE_W-1:0]  page_id,
	input  logic                          mark_dirty,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bplru_pkg::STAT_W-1:0]  status,
	output logic [bplru_pkg::FRAME_W-1:0] frame_slot,
	output logic                          was_hit,
	output logic                          read_needed,
	output logic                          write_needed,
	output logic [bplru_pkg::PAGE_W-1:0]  write_page_id,
	output logic [bplru_pkg::CNT_W-1:0]   hit_total,
	output logic [bplru_pkg::CNT_W-1:0]   miss_total
);
	import bplru_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// sequencer
	bplru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// frame table and result path
	bplru_dp #(
		.FRAMES (FRAMES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req_type),
		.page_id       (page_id),
		.mark_dirty    (mark_dirty),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.frame_slot    (frame_slot),
		.was_hit       (was_hit),
		.read_needed   (read_needed),
		.write_needed  (write_needed),
		.write_page_id (write_page_id),
		.hit_total     (hit_total),
		.miss_total    (miss_total)
	);

endmodule

### rtl/bplru_ctrl.sv
// Sequencer for one request: accept, walk the frame table, commit.
module bplru_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bplru_pkg::ctl_sts_t sts,
	output bplru_pkg::ctl_cmd_t cmd
);
	import bplru_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_LAST,
		S_COMMIT
	} state_t;

	state_t state_q;

	assign in_stall = (state_q != S_IDLE);

	// commands follow the state directly
	always_comb begin
		cmd.start   = (state_q == S_IDLE) && in_valid;
		cmd.scan_rd = (state_q == S_SCAN);
		cmd.commit  = (state_q == S_COMMIT) && sts.slot_free;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (sts.addr_last) state_q <= S_LAST;
				end
				S_LAST: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (sts.slot_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/bplru_dp.sv
// Frame table, scan trackers, update logic and result register.
`include "assert_macros.svh"

module bplru_dp #(
	parameter int FRAMES = bplru_pkg::FRAMES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bplru_pkg::ctl_cmd_t           cmd,
	output bplru_pkg::ctl_sts_t           sts,
	input  logic [bplru_pkg::REQ_W-1:0]   req_type,
	input  logic [bplru_pkg::PAGE_W-1:0]  page_id,
	input  logic                          mark_dirty,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bplru_pkg::STAT_W-1:0]  status,
	output logic [bplru_pkg::FRAME_W-1:0] frame_slot,
	output logic                          was_hit,
	output logic                          read_needed,
	output logic                          write_needed,
	output logic [bplru_pkg::PAGE_W-1:0]  write_page_id,
	output logic [bplru_pkg::CNT_W-1:0]   hit_total,
	output logic [bplru_pkg::CNT_W-1:0]   miss_total
);
	import bplru_pkg::*;

	localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAMES - 1);

	// frame table storage
	entry_t            mem [FRAMES];
	logic [FRAMES-1:0] valid_q;

	// latched request
	logic [REQ_W-1:0]  req_q;
	logic [PAGE_W-1:0] page_q;
	logic              dirty_q;

	// scan address and read stage
	logic [IDX_W-1:0]  addr_q;
	logic              scan_vld_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              vld_s1;
	entry_t            rdata_s1;

	// scan trackers
	logic              match_found_q;
	logic [IDX_W-1:0]  match_idx_q;
	entry_t            match_ent_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;
	logic              vict_found_q;
	logic [IDX_W-1:0]  vict_idx_q;
	entry_t            vict_ent_q;

	// global counters
	logic [STAMP_W-1:0] use_clock_q;
	logic [CNT_W-1:0]   hits_q;
	logic [CNT_W-1:0]   misses_q;

	// result register
	logic               out_valid_q;
	logic [STAT_W-1:0]  status_q;
	logic [FRAME_W-1:0] frame_q;
	logic               hit_q;
	logic               rd_q;
	logic               wr_q;
	logic [PAGE_W-1:0]  wpage_q;

	// update decisions
	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	entry_t             wr_ent;
	logic               set_valid;
	logic [STAMP_W-1:0] clock_nx;
	logic [CNT_W-1:0]   hits_nx;
	logic [CNT_W-1:0]   misses_nx;
	logic [STAT_W-1:0]  stat_nx;
	logic [FRAME_W-1:0] frame_nx;
	logic               hit_nx;
	logic               rd_nx;
	logic               wr_nx;
	logic [PAGE_W-1:0]  wpage_nx;
	entry_t             load_ent;

	assign sts.addr_last = (addr_q == LAST_IDX);
	assign sts.slot_free = !out_valid_q || !out_stall;

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_idx] <= wr_ent;
		if (cmd.scan_rd) rdata_s1 <= mem[addr_q];
	end

	// valid bits, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.commit && set_valid) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	// request latch, scan address and read stage payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_q   <= req_type;
			page_q  <= page_id;
			dirty_q <= mark_dirty;
		end
		if (cmd.start) begin
			addr_q <= '0;
		end else if (cmd.scan_rd) begin
			addr_q <= addr_q + IDX_W'(1);
		end
		if (cmd.scan_rd) begin
			idx_s1 <= addr_q;
			vld_s1 <= valid_q[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.scan_rd;
		end
	end

	// trackers: first match, lowest free frame, oldest unpinned frame
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			vict_found_q  <= 1'b0;
		end else if (scan_vld_s1) begin
			if (vld_s1 && rdata_s1.page == page_q && !match_found_q) begin
				match_found_q <= 1'b1;
				match_idx_q   <= idx_s1;
				match_ent_q   <= rdata_s1;
			end
			if (!vld_s1 && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
			if (vld_s1 && rdata_s1.pins == '0 &&
			    (!vict_found_q || rdata_s1.stamp < vict_ent_q.stamp)) begin
				vict_found_q <= 1'b1;
				vict_idx_q   <= idx_s1;
				vict_ent_q   <= rdata_s1;
			end
		end
	end

	// entry written when a page is brought in
	always_comb begin
		load_ent.page  = page_q;
		load_ent.pins  = PIN_W'(1);
		load_ent.dirty = 1'b0;
		load_ent.stamp = use_clock_q;
	end

	// request outcome from the finished scan
	always_comb begin
		wr_en     = 1'b0;
		wr_idx    = match_idx_q;
		wr_ent    = match_ent_q;
		set_valid = 1'b0;
		clock_nx  = use_clock_q;
		hits_nx   = hits_q;
		misses_nx = misses_q;
		stat_nx   = STAT_OK;
		frame_nx  = '0;
		hit_nx    = 1'b0;
		rd_nx     = 1'b0;
		wr_nx     = 1'b0;
		wpage_nx  = '0;
		unique case (req_q)
			REQ_FETCH: begin
				if (match_found_q) begin
					wr_en        = 1'b1;
					wr_ent.stamp = use_clock_q;
					if (match_ent_q.pins != PIN_MAX) wr_ent.pins = match_ent_q.pins + PIN_W'(1);
					clock_nx = use_clock_q + STAMP_W'(1);
					if (hits_q != CNT_MAX) hits_nx = hits_q + CNT_W'(1);
					frame_nx = FRAME_W'(match_idx_q);
					hit_nx   = 1'b1;
				end else if (free_found_q || vict_found_q) begin
					wr_en     = 1'b1;
					wr_idx    = free_found_q ? free_idx_q : vict_idx_q;
					wr_ent    = load_ent;
					set_valid = free_found_q;
					clock_nx  = use_clock_q + STAMP_W'(1);
					if (misses_q != CNT_MAX) misses_nx = misses_q + CNT_W'(1);
					frame_nx = FRAME_W'(free_found_q ? free_idx_q : vict_idx_q);
					rd_nx    = 1'b1;
					// dirty victim goes back to disk first
					if (!free_found_q && vict_ent_q.dirty) begin
						wr_nx    = 1'b1;
						wpage_nx = vict_ent_q.page;
					end
				end else begin
					stat_nx = STAT_NO_VICTIM;
				end
			end
			REQ_UNPIN: begin
				if (match_found_q) begin
					wr_en = 1'b1;
					if (match_ent_q.pins != '0) wr_ent.pins = match_ent_q.pins - PIN_W'(1);
					if (dirty_q) wr_ent.dirty = 1'b1;
					frame_nx = FRAME_W'(match_idx_q);
				end else begin
					stat_nx = STAT_ABSENT;
				end
			end
			REQ_FLUSH: begin
				if (match_found_q) begin
					wr_en        = 1'b1;
					wr_ent.dirty = 1'b0;
					wr_nx        = 1'b1;
					wpage_nx     = page_q;
					frame_nx     = FRAME_W'(match_idx_q);
				end else begin
					stat_nx = STAT_ABSENT;
				end
			end
			default: begin
				// unknown request: report counters only
			end
		endcase
		wr_en = wr_en && cmd.commit;
	end

	// counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_clock_q <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
		end else if (cmd.commit) begin
			use_clock_q <= clock_nx;
			hits_q      <= hits_nx;
			misses_q    <= misses_nx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= stat_nx;
			frame_q  <= frame_nx;
			hit_q    <= hit_nx;
			rd_q     <= rd_nx;
			wr_q     <= wr_nx;
			wpage_q  <= wpage_nx;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign frame_slot    = frame_q;
	assign was_hit       = hit_q;
	assign read_needed   = rd_q;
	assign write_needed  = wr_q;
	assign write_page_id = wpage_q;
	assign hit_total     = hits_q;
	assign miss_total    = misses_q;

	// a waiting result is never overwritten
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, cmd.commit && out_valid_q && out_stall)
	// a failed request carries no frame and no disk traffic
	`ASSERT_PROP(a_fail_clean, clk, arst_n, (out_valid_q && status_q != STAT_OK) |-> (frame_q == '0 && !rd_q && !wr_q))
	// a hit never asks for a read
	`ASSERT_NEVER(a_hit_no_read, clk, arst_n, out_valid_q && hit_q && rd_q)
	// the use clock moves only when a request commits
	`ASSERT_PROP(a_clock_on_commit, clk, arst_n, !cmd.commit |=> $stable(use_clock_q))

endmodule

### test/buffer_pool_lru_frame_manager_unit_tb.sv
// Self-checking testbench for the buffer pool LRU frame manager: frame table mirror and traffic.
`timescale 1ns / 100ps

import bplru_pkg::*;

// one result item as seen on the output channel
typedef struct packed {
	logic [STAT_W-1:0]  status;
	logic [FRAME_W-1:0] frame;
	logic               hit;
	logic               rd;
	logic               wr;
	logic [PAGE_W-1:0]  wpage;
	logic [CNT_W-1:0]   hits;
	logic [CNT_W-1:0]   misses;
} pool_result_t;

// Mirror of the frame table plus the queue of results it predicts.
class pool_scoreboard;
	logic [PAGE_W-1:0]  page_of  [FRAMES_DEF];
	bit                 resident [FRAMES_DEF];
	logic [PIN_W-1:0]   pins     [FRAMES_DEF];
	bit                 modified [FRAMES_DEF];
	logic [STAMP_W-1:0] stamp    [FRAMES_DEF];
	logic [STAMP_W-1:0] use_clock;
	logic [CNT_W-1:0]   hit_cnt;
	logic [CNT_W-1:0]   miss_cnt;
	pool_result_t       expected_q[$];
	int unsigned        mismatches;

	function new();
		for (int i = 0; i < FRAMES_DEF; i++) begin
			page_of[i]  = '0;
			resident[i] = 1'b0;
			pins[i]     = '0;
			modified[i] = 1'b0;
			stamp[i]    = '0;
		end
		use_clock  = '0;
		hit_cnt    = '0;
		miss_cnt   = '0;
		mismatches = 0;
	endfunction

	function int find_page(logic [PAGE_W-1:0] pg);
		for (int i = 0; i < FRAMES_DEF; i++)
			if (resident[i] && page_of[i] == pg)
				return i;
		return -1;
	endfunction

	// bring a page into frame f, pinned once
	function void load_page(int f, logic [PAGE_W-1:0] pg);
		resident[f] = 1'b1;
		page_of[f]  = pg;
		stamp[f]    = use_clock;
		use_clock   = use_clock + 1'b1;
		pins[f]     = PIN_W'(1);
		modified[f] = 1'b0;
		if (miss_cnt != CNT_MAX)
			miss_cnt = miss_cnt + 1'b1;
	endfunction

	// Apply one accepted request to the mirror and queue its result.
	function void note_request(logic [REQ_W-1:0] req, logic [PAGE_W-1:0] pg, logic dirty);
		pool_result_t r;
		int f;
		int v;
		r = '0;
		f = find_page(pg);
		case (req)
		REQ_FETCH: begin
			if (f >= 0) begin
				stamp[f]  = use_clock;
				use_clock = use_clock + 1'b1;
				if (pins[f] != PIN_MAX)
					pins[f] = pins[f] + 1'b1;
				if (hit_cnt != CNT_MAX)
					hit_cnt = hit_cnt + 1'b1;
				r.frame = f[FRAME_W-1:0];
				r.hit   = 1'b1;
			end else begin
				// lowest free frame first
				for (int i = 0; i < FRAMES_DEF && f < 0; i++)
					if (!resident[i])
						f = i;
				if (f >= 0) begin
					load_page(f, pg);
					r.frame = f[FRAME_W-1:0];
					r.rd    = 1'b1;
				end else begin
					// oldest unpinned frame, lowest index on a tie
					v = -1;
					for (int i = 0; i < FRAMES_DEF; i++)
						if (pins[i] == 0 && (v < 0 || stamp[i] < stamp[v]))
							v = i;
					if (v < 0) begin
						r.status = STAT_NO_VICTIM;
					end else begin
						if (modified[v]) begin
							r.wr    = 1'b1;
							r.wpage = page_of[v];
						end
						load_page(v, pg);
						r.frame = v[FRAME_W-1:0];
						r.rd    = 1'b1;
					end
				end
			end
		end
		REQ_UNPIN: begin
			if (f < 0) begin
				r.status = STAT_ABSENT;
			end else begin
				if (pins[f] != 0)
					pins[f] = pins[f] - 1'b1;
				if (dirty)
					modified[f] = 1'b1;
				r.frame = f[FRAME_W-1:0];
			end
		end
		REQ_FLUSH: begin
			if (f < 0) begin
				r.status = STAT_ABSENT;
			end else begin
				r.wr        = 1'b1;
				r.wpage     = pg;
				modified[f] = 1'b0;
				r.frame     = f[FRAME_W-1:0];
			end
		end
		default: ;
		endcase
		r.hits   = hit_cnt;
		r.misses = miss_cnt;
		expected_q = {expected_q, r};
	endfunction

	function void field_check(string name, logic [63:0] exp_v, logic [63:0] got_v);
		if (got_v !== exp_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on %s: expected %0h, got %0h", name, exp_v, got_v);
		end
	endfunction

	// Compare one result item against the oldest prediction.
	function void check_result(pool_result_t got);
		pool_result_t exp_r;
		if (expected_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result with nothing expected: status %0h frame %0h",
					got.status, got.frame);
			return;
		end
		exp_r = expected_q.pop_front();
		field_check("status", 64'(exp_r.status), 64'(got.status));
		field_check("frame_slot", 64'(exp_r.frame), 64'(got.frame));
		field_check("was_hit", 64'(exp_r.hit), 64'(got.hit));
		field_check("read_needed", 64'(exp_r.rd), 64'(got.rd));
		field_check("write_needed", 64'(exp_r.wr), 64'(got.wr));
		field_check("write_page_id", 64'(exp_r.wpage), 64'(got.wpage));
		field_check("hit_total", 64'(exp_r.hits), 64'(got.hits));
		field_check("miss_total", 64'(exp_r.misses), 64'(got.misses));
	endfunction

	function int unsigned pending();
		return expected_q.size();
	endfunction

	function int unsigned failures();
		return mismatches + expected_q.size();
	endfunction
endclass

module buffer_pool_lru_frame_manager_unit_tb;

	localparam logic [REQ_W-1:0] REQ_BAD   = 2'd3;
	localparam int WATCHDOG_LIMIT          = 4000;
	localparam int RANDOM_ITEMS            = 1850;
	localparam int HOT_HITS                = 20;
	localparam logic [PAGE_W-1:0] HOT_PAGE = 31'h1CEB_00DA;
	localparam logic [PAGE_W-1:0] NEW_BASE = 31'h3000_0000;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic [REQ_W-1:0]    req_type   = REQ_FETCH;
	logic [PAGE_W-1:0]   page_id    = '0;
	logic                mark_dirty = 1'b0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [STAT_W-1:0]   status;
	logic [FRAME_W-1:0]  frame_slot;
	logic                was_hit;
	logic                read_needed;
	logic                write_needed;
	logic [PAGE_W-1:0]   write_page_id;
	logic [CNT_W-1:0]    hit_total;
	logic [CNT_W-1:0]    miss_total;

	pool_scoreboard      sb;
	pool_result_t        seen_item;
	logic                idle_on      = 1'b1;
	int unsigned         stall_left   = 0;
	int unsigned         quiet_cycles = 0;
	logic [PAGE_W-1:0]   held_pages[$];
	logic [PAGE_W-1:0]   hot_pages[12] = '{31'h0, 31'h1, 31'h7FFF_FFFF, 31'h7FFF_FFFE,
		31'h4000_0000, 31'h2, 31'h2AAA_AAAA, 31'h5555_5555, 31'h3, 31'h4, 31'h5, 31'h6};

	buffer_pool_lru_frame_manager_unit #(
		.FRAMES(FRAMES_DEF)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.page_id(page_id),
		.mark_dirty(mark_dirty),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.frame_slot(frame_slot),
		.was_hit(was_hit),
		.read_needed(read_needed),
		.write_needed(write_needed),
		.write_page_id(write_page_id),
		.hit_total(hit_total),
		.miss_total(miss_total)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver stalls in random bursts while idling is on
	always @(posedge clk) begin
		if (!idle_on) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 15);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_item.status = status;
			seen_item.frame  = frame_slot;
			seen_item.hit    = was_hit;
			seen_item.rd     = read_needed;
			seen_item.wr     = write_needed;
			seen_item.wpage  = write_page_id;
			seen_item.hits   = hit_total;
			seen_item.misses = miss_total;
			sb.check_result(seen_item);
		end
	end

	// watchdog: too long with no item moving on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL buffer_pool_lru_frame_manager_unit");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one request, hold it until taken, then update the mirror.
	task automatic send_request(input logic [REQ_W-1:0] req, input logic [PAGE_W-1:0] pg,
		input logic dirty);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req_type   <= req;
		page_id    <= pg;
		mark_dirty <= dirty;
		in_valid   <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_request(req, pg, dirty);
		// track pins this stimulus still has to give back
		if (req == REQ_FETCH) begin
			held_pages = {held_pages, pg};
		end else if (req == REQ_UNPIN) begin
			for (int i = 0; i < held_pages.size(); i++)
				if (held_pages[i] == pg) begin
					held_pages.delete(i);
					break;
				end
		end
	endtask

	// sender pauses until every outstanding result is back
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic logic [PAGE_W-1:0] pick_page();
		if ($urandom_range(0, 9) == 0)
			return PAGE_W'($urandom());
		return hot_pages[$urandom_range(0, 11)];
	endfunction

	// Mostly fetch/unpin pairs over a small working set, plus flushes and noise.
	task automatic random_request();
		logic [REQ_W-1:0]  req;
		logic [PAGE_W-1:0] pg;
		int unsigned       roll;
		int unsigned       unpin_thr;
		roll      = $urandom_range(0, 99);
		unpin_thr = (held_pages.size() > 6) ? 70 : 40;
		if (roll < 4)
			req = REQ_BAD;
		else if (roll < 18)
			req = REQ_FLUSH;
		else if (roll < unpin_thr)
			req = REQ_UNPIN;
		else
			req = REQ_FETCH;
		pg = pick_page();
		if (held_pages.size() != 0) begin
			if ((req == REQ_UNPIN && $urandom_range(0, 9) != 0) ||
				(req == REQ_FLUSH && $urandom_range(0, 1) != 0))
				pg = held_pages[$urandom_range(0, held_pages.size() - 1)];
		end
		send_request(req, pg, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// empty pool: unpin and flush miss, unknown request ignored
		send_request(REQ_UNPIN, 31'h5, 1'b1);
		send_request(REQ_FLUSH, 31'h5, 1'b0);
		send_request(REQ_BAD, 31'h7FFF_FFFF, 1'b1);
		// fill every frame from the free list
		send_request(REQ_FETCH, 31'h0, 1'b0);
		send_request(REQ_FETCH, 31'h7FFF_FFFF, 1'b1);
		send_request(REQ_FETCH, 31'h1, 1'b0);
		send_request(REQ_FETCH, 31'h7FFF_FFFE, 1'b0);
		send_request(REQ_FETCH, 31'h2, 1'b0);
		send_request(REQ_FETCH, 31'h3, 1'b0);
		send_request(REQ_FETCH, 31'h4, 1'b0);
		send_request(REQ_FETCH, 31'h5, 1'b0);
		send_request(REQ_FETCH, 31'h7FFF_FFFF, 1'b0);
		// all pinned: no victim
		send_request(REQ_FETCH, 31'h9, 1'b0);
		// unpin down past zero, mark one dirty
		send_request(REQ_UNPIN, 31'h0, 1'b1);
		send_request(REQ_UNPIN, 31'h7FFF_FFFF, 1'b0);
		send_request(REQ_UNPIN, 31'h7FFF_FFFF, 1'b0);
		send_request(REQ_UNPIN, 31'h7FFF_FFFF, 1'b0);
		// dirty victim gets written back
		send_request(REQ_FETCH, 31'h9, 1'b0);
		// flushed victim needs no write-back
		send_request(REQ_UNPIN, 31'h1, 1'b1);
		send_request(REQ_FLUSH, 31'h1, 1'b0);
		send_request(REQ_UNPIN, 31'h2, 1'b0);
		send_request(REQ_FETCH, 31'hA, 1'b1);
		wait_drained();

		// random traffic; idling off in every third segment and at the tail
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 200 == 0)
				idle_on <= (n < 1400) && ((n / 200) % 3 != 2);
			if (n == 900)
				wait_drained();
			random_request();
		end

		// release all pins, then pile many pins onto one page
		while (held_pages.size() != 0)
			send_request(REQ_UNPIN, held_pages[0], 1'($urandom_range(0, 1)));
		send_request(REQ_FETCH, HOT_PAGE, 1'b0);
		for (int n = 0; n < HOT_HITS; n++)
			send_request(REQ_FETCH, HOT_PAGE, 1'b0);
		// pin every other frame, so a heavily pinned page must still block eviction
		for (int k = 0; k < FRAMES_DEF; k++)
			send_request(REQ_FETCH, NEW_BASE + PAGE_W'(k), 1'b0);
		send_request(REQ_UNPIN, HOT_PAGE, 1'b1);
		send_request(REQ_FETCH, NEW_BASE + PAGE_W'(FRAMES_DEF), 1'b0);
		send_request(REQ_FLUSH, HOT_PAGE, 1'b0);

		wait_drained();
		repeat (FRAMES_DEF + 4) @(posedge clk);
		if (sb.pending() != 0)
			$display("%0d results never arrived", sb.pending());
		if (sb.failures() == 0)
			$display("PASS buffer_pool_lru_frame_manager_unit");
		else
			$display("FAIL buffer_pool_lru_frame_manager_unit");
		$finish;
	end

endmodule
